// ----- rtl/core/ucf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Universal comb filter package
// Shared constants, register codes, controller states and the command and
// status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ucf_pkg;

  localparam int UCF_MAX_DELAY = 2048;
  localparam int UCF_CHANNELS  = 2;
  localparam int UCF_LANES     = 2;

  localparam int SMP_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LEN_CFG_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_CFG_W-1:0] RST_DELAY_LENGTH     = 12'd1024;
  localparam logic [GAIN_W-1:0]    RST_BLEND_GAIN       = 16'h4000;
  localparam logic [GAIN_W-1:0]    RST_FEEDBACK_GAIN    = 16'h0000;
  localparam logic [GAIN_W-1:0]    RST_FEEDFORWARD_GAIN = 16'h0000;
  localparam logic [GAIN_W-1:0]    RST_WET_LEVEL        = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH     = 3'd0,
    REG_BLEND_GAIN       = 3'd1,
    REG_FEEDBACK_GAIN    = 3'd2,
    REG_FEEDFORWARD_GAIN = 3'd3,
    REG_WET_LEVEL        = 3'd4
  } ucf_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL_FB,
    ST_MUL_FF,
    ST_MUL_BL,
    ST_MUL_DRY,
    ST_MUL_WET,
    ST_FIN
  } ucf_state_t;

  typedef enum logic [2:0] {
    MUL_FB,
    MUL_FF,
    MUL_BL,
    MUL_DRY,
    MUL_WET
  } ucf_mul_t;

  typedef struct packed {
    logic     clear_step;
    logic     load;
    logic     rd_en;
    logic     mul_en;
    ucf_mul_t mul_sel;
    logic     ld_xh;
    logic     ld_y_init;
    logic     ld_y_add;
    logic     ld_mix;
    logic     wr_en;
    logic     fin;
  } ucf_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ucf_status_t;

endpackage

// ----- rtl/core/ucf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Universal comb filter controller
// Sequences the memory clearing pass, the per-word read, multiply and
// write-back steps, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ucf_ctrl
  import ucf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ucf_status_t status,
  output ucf_cmd_t    cmd
);

  ucf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       fin_fire;

  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (status.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_MUL_FB;
      ST_MUL_FB:  state_nxt = ST_MUL_FF;
      ST_MUL_FF:  state_nxt = ST_MUL_BL;
      ST_MUL_BL:  state_nxt = ST_MUL_DRY;
      ST_MUL_DRY: state_nxt = ST_MUL_WET;
      ST_MUL_WET: state_nxt = ST_FIN;
      ST_FIN:     if (fin_fire) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_FB;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_MUL_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FB;
      end
      ST_MUL_FF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FF;
        cmd.ld_xh   = 1'b1;
      end
      ST_MUL_BL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_BL;
        cmd.ld_y_init = 1'b1;
        cmd.wr_en     = 1'b1;
      end
      ST_MUL_DRY: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_DRY;
        cmd.ld_y_add = 1'b1;
      end
      ST_MUL_WET: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WET;
        cmd.ld_mix  = 1'b1;
      end
      ST_FIN: begin
        cmd.fin = fin_fire;
        if (fin_fire) out_valid_nxt = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/ucf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Universal comb filter datapath
// Configuration registers, ring pointer, one delay memory and one multiplier
// lane per channel, and the output word register.
// ----------------------------------------------------------------------------
module ucf_datapath
  import ucf_pkg::*;
#(
  parameter int MAX_DELAY = UCF_MAX_DELAY,
  parameter int CHANNELS  = UCF_CHANNELS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [SMP_W-1:0] sample_0,
  input  logic signed [SMP_W-1:0] sample_1,
  output logic signed [SMP_W-1:0] out_0,
  output logic signed [SMP_W-1:0] out_1,
  input  ucf_cmd_t                cmd,
  output ucf_status_t             status
);

  localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LEN_W = $clog2(MAX_DELAY + 1);
  localparam int CMP_W = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam int T14_W = 18;
  localparam int Y_W   = 19;
  localparam int A_W   = 19;
  localparam int B_W   = 18;
  localparam int P_W   = A_W + B_W;
  localparam int MIX_W = P_W + 1;
  localparam int Q_W   = MIX_W - 15;
  localparam logic [16:0] WET_ONE = 17'd32768;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [Q_W-1:0] v);
    if (v > Q_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -Q_W'(32768)) begin
      return 16'sh8000;
    end
    return v[SMP_W-1:0];
  endfunction

  logic [LEN_CFG_W-1:0]    delay_len_r;
  logic signed [GAIN_W-1:0] blend_r, fb_r, ff_r;
  logic [GAIN_W-1:0]        wet_r;
  logic [PTR_W-1:0]         ptr_r, ptr_cur_r, clr_cnt_r;
  logic                     len_zero_r;

  logic [CMP_W-1:0]         len_ext, len_eff, ptr_inc;
  logic [PTR_W-1:0]         ptr_start, mem_addr;
  logic [16:0]              wet_eff;
  logic signed [B_W-1:0]    wet_op, dry_op;
  logic signed [SMP_W-1:0]  x_in [UCF_LANES];
  logic signed [SMP_W-1:0]  y_out [UCF_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_len_r <= RST_DELAY_LENGTH;
      blend_r     <= RST_BLEND_GAIN;
      fb_r        <= RST_FEEDBACK_GAIN;
      ff_r        <= RST_FEEDFORWARD_GAIN;
      wet_r       <= RST_WET_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_LENGTH:     delay_len_r <= cfg_wdata[LEN_CFG_W-1:0];
        REG_BLEND_GAIN:       blend_r     <= cfg_wdata;
        REG_FEEDBACK_GAIN:    fb_r        <= cfg_wdata;
        REG_FEEDFORWARD_GAIN: ff_r        <= cfg_wdata;
        REG_WET_LEVEL:        wet_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign len_ext   = CMP_W'(delay_len_r);
  assign len_eff   = (len_ext > CMP_W'(MAX_DELAY)) ? CMP_W'(MAX_DELAY) : len_ext;
  assign ptr_start = ((len_eff == '0) || (CMP_W'(ptr_r) >= len_eff)) ? '0 : ptr_r;
  assign ptr_inc   = CMP_W'(ptr_cur_r) + CMP_W'(1);
  assign mem_addr  = cmd.clear_step ? clr_cnt_r : ptr_cur_r;

  assign status.clear_last = (clr_cnt_r == PTR_W'(MAX_DELAY - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + PTR_W'(1);
      if (cmd.fin && !len_zero_r) begin
        ptr_r <= (ptr_inc >= len_eff) ? '0 : ptr_inc[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr_cur_r  <= ptr_start;
      len_zero_r <= (len_eff == '0);
    end
  end

  assign wet_eff = ({1'b0, wet_r} > WET_ONE) ? WET_ONE : {1'b0, wet_r};
  assign wet_op  = $signed({1'b0, wet_eff});
  assign dry_op  = $signed({1'b0, WET_ONE}) - wet_op;

  assign x_in[0] = sample_0;
  assign x_in[1] = sample_1;

  for (genvar ch = 0; ch < UCF_LANES; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_on
      logic [SMP_W-1:0]        mem [MAX_DELAY];
      logic signed [SMP_W-1:0] x_r, rd_r, xh_r, out_r, d_val;
      logic signed [Y_W-1:0]   y_r;
      logic signed [P_W-1:0]   p_r, mix_r, p_t;
      logic signed [A_W-1:0]   a_op;
      logic signed [B_W-1:0]   b_op;
      logic signed [T14_W-1:0] t14;
      logic signed [Y_W-1:0]   xh_sum;
      logic signed [MIX_W-1:0] mix_sum;

      assign d_val = len_zero_r ? '0 : rd_r;

      always_comb begin
        case (cmd.mul_sel)
          MUL_FB: begin
            a_op = A_W'(d_val);
            b_op = B_W'(fb_r);
          end
          MUL_FF: begin
            a_op = A_W'(d_val);
            b_op = B_W'(ff_r);
          end
          MUL_BL: begin
            a_op = A_W'(xh_r);
            b_op = B_W'(blend_r);
          end
          MUL_DRY: begin
            a_op = A_W'(x_r);
            b_op = dry_op;
          end
          MUL_WET: begin
            a_op = y_r;
            b_op = wet_op;
          end
          default: begin
            a_op = '0;
            b_op = '0;
          end
        endcase
      end

      assign p_t     = p_r + P_W'(8192);
      assign t14     = p_t[31:14];
      assign xh_sum  = Y_W'(x_r) + Y_W'(t14);
      assign mix_sum = MIX_W'(mix_r) + MIX_W'(p_r) + MIX_W'(16384);

      always_ff @(posedge clk) begin
        if (cmd.load) x_r <= x_in[ch];
        if (cmd.rd_en) rd_r <= mem[mem_addr];
        if (cmd.clear_step) begin
          mem[mem_addr] <= '0;
        end else if (cmd.wr_en && !len_zero_r) begin
          mem[mem_addr] <= xh_r;
        end
        if (cmd.mul_en) p_r <= a_op * b_op;
        if (cmd.ld_xh) xh_r <= sat16(Q_W'(xh_sum));
        if (cmd.ld_y_init) y_r <= Y_W'(t14);
        if (cmd.ld_y_add) y_r <= y_r + Y_W'(t14);
        if (cmd.ld_mix) mix_r <= p_r;
        if (cmd.fin) out_r <= sat16(mix_sum[MIX_W-1:15]);
      end

      assign y_out[ch] = out_r;
    end else begin : g_off
      assign y_out[ch] = '0;
    end
  end

  assign out_0 = y_out[0];
  assign out_1 = y_out[1];

endmodule

// ----- rtl/core/universal_comb_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Universal comb filter top level
// Two-channel comb filter with feedback, feedforward, blend and wet/dry mix.
//
// The input channel (in_valid/in_ready) takes one frame word holding one
// Q1.15 sample per channel; the output channel (out_valid/out_ready) returns
// one filtered frame word per input word. Gains and the delay length are set
// through the cfg_we/cfg_index/cfg_wdata write port; the user must write them
// only while the block is idle, which the block itself does not enforce. A word
// is accepted only in the idle state. It then takes one delay memory read and
// five steps of each channel's own multiplier, so the result is registered in
// the final step and no new word is accepted until that step is done.
// After reset a clearing pass zeroes every address of the delay memories, one
// address of every channel per cycle; in_ready stays low until it ends.
// A finished result waits in the output register while the receiver stalls;
// a next word is still accepted and worked on, and it waits in its final
// step until the output register has been taken.
// ----------------------------------------------------------------------------
module universal_comb_filter_top
  import ucf_pkg::*;
#(
  parameter int MAX_DELAY = UCF_MAX_DELAY,
  parameter int CHANNELS  = UCF_CHANNELS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample_0,
  input  logic signed [SMP_W-1:0] in_sample_1,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_0,
  output logic signed [SMP_W-1:0] out_1
);

  ucf_cmd_t    cmd;
  ucf_status_t status;

  ucf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ucf_datapath #(
    .MAX_DELAY (MAX_DELAY),
    .CHANNELS  (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sample_0  (in_sample_0),
    .sample_1  (in_sample_1),
    .out_0     (out_0),
    .out_1     (out_1),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
